// ===== src/qrds_pkg.sv =====
// Package for the QR data segment encoder: shared types, codes, constants and
// the character and header decode functions. No dependencies.
package qrds_pkg;

  // Default limits handed to the top-level parameters
  localparam int unsigned MAX_DCW_DEF = 2956;
  localparam int unsigned MAX_RES_DEF = 64;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_DCW     = 2'd2;
  localparam logic [1:0] REG_MLEN    = 2'd3;

  // Coding modes; the unused code behaves as byte mode
  localparam logic [1:0] MODE_NUMERIC = 2'd0;
  localparam logic [1:0] MODE_ALNUM   = 2'd1;
  localparam logic [1:0] MODE_BYTE    = 2'd2;

  // Item kinds
  localparam logic FUNC_CHAR   = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  // Pad codewords and counter ceilings
  localparam logic [7:0]  PAD_FIRST  = 8'hEC;
  localparam logic [7:0]  PAD_SECOND = 8'h11;
  localparam logic [14:0] TOTAL_SAT  = 15'h7FFF;
  localparam logic [11:0] CWE_SAT    = 12'hFFF;

  typedef enum logic [1:0] {
    PH_COLLECT,
    PH_PAD,
    PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP1,
    S_PREP2,
    S_HIND,
    S_HCNT,
    S_GRP,
    S_TERM,
    S_ALIGN,
    S_PAD,
    S_FIN
  } seq_state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  version;
    logic [11:0] dcw;
    logic [12:0] mlen;
  } cfg_t;

  // Sequencer to packer
  typedef struct packed {
    logic       bit_push;
    logic       bit_val;
    logic       byte_push;
    logic [7:0] byte_val;
    logic       clr;
    logic       fin;
    logic       eod;
    logic [1:0] status;
  } pk_cmd_t;

  // Packer to sequencer
  typedef struct packed {
    logic       rdy;
    logic       stg_vld;
    logic       out_free;
    logic [2:0] cnt;
    logic       gen;
  } pk_stat_t;

  // Width of the character count field
  function automatic logic [4:0] count_width(input logic [1:0] mode,
                                             input logic [5:0] version);
    logic [4:0] w;
    unique case (mode)
      MODE_NUMERIC: w = (version < 6'd10) ? 5'd10 : (version < 6'd27) ? 5'd12 : 5'd14;
      MODE_ALNUM:   w = (version < 6'd10) ? 5'd9  : (version < 6'd27) ? 5'd11 : 5'd13;
      default:      w = (version < 6'd10) ? 5'd8  : 5'd16;
    endcase
    return w;
  endfunction

  // Four-bit mode indicator
  function automatic logic [3:0] mode_ind(input logic [1:0] mode);
    logic [3:0] ind;
    unique case (mode)
      MODE_NUMERIC: ind = 4'b0001;
      MODE_ALNUM:   ind = 4'b0010;
      default:      ind = 4'b0100;
    endcase
    return ind;
  endfunction

  // Alphanumeric value: {valid, value}
  function automatic logic [6:0] alnum_value(input logic [7:0] c);
    logic [6:0] r;
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r = {1'b1, d[5:0]};
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h37;
      r = {1'b1, d[5:0]};
    end else begin
      unique case (c)
        8'h20:   r = {1'b1, 6'd36};
        8'h24:   r = {1'b1, 6'd37};
        8'h25:   r = {1'b1, 6'd38};
        8'h2A:   r = {1'b1, 6'd39};
        8'h2B:   r = {1'b1, 6'd40};
        8'h2D:   r = {1'b1, 6'd41};
        8'h2E:   r = {1'b1, 6'd42};
        8'h2F:   r = {1'b1, 6'd43};
        8'h3A:   r = {1'b1, 6'd44};
        default: r = {1'b0, 6'd0};
      endcase
    end
    return r;
  endfunction

endpackage

// ===== src/qrds_pack.sv =====
// Bit-to-codeword packer: seven-bit shift register, one-deep staging byte and
// the output register of the result channel. Depends on qrds_pkg.
module qrds_pack (
  input  logic               clk,
  input  logic               rst_n,
  input  qrds_pkg::pk_cmd_t  cmd,
  output qrds_pkg::pk_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_codeword,
  output logic               out_last_of_run,
  output logic               out_end_of_data,
  output logic [1:0]         out_status_code
);

  logic [6:0] sr_r;
  logic [2:0] cnt_r;
  logic [7:0] stg_r;
  logic       stg_vld_r;
  logic       out_vld_r;
  logic [7:0] ocw_r;
  logic       olast_r;
  logic       oeod_r;
  logic [1:0] ost_r;

  logic       out_free;
  logic       gen;
  logic       move;
  logic [7:0] new_byte;

  // Handshake side conditions
  assign out_free = !out_vld_r || out_ready;
  assign gen      = (cmd.bit_push && (cnt_r == 3'd7)) || cmd.byte_push;
  assign move     = stg_vld_r && out_free && (gen || cmd.fin);
  assign new_byte = cmd.byte_push ? cmd.byte_val : {sr_r, cmd.bit_val};

  assign stat.rdy      = !stg_vld_r || out_free;
  assign stat.stg_vld  = stg_vld_r;
  assign stat.out_free = out_free;
  assign stat.cnt      = cnt_r;
  assign stat.gen      = gen;

  // Control state: bit count, staging and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= 3'd0;
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        cnt_r <= 3'd0;
      end else if (cmd.bit_push) begin
        cnt_r <= cnt_r + 3'd1;
      end
      if (gen) begin
        stg_vld_r <= 1'b1;
      end else if (move) begin
        stg_vld_r <= 1'b0;
      end
      if (move) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload: shift bits in, hold staged byte, load the output register
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      sr_r <= 7'd0;
    end else if (cmd.bit_push) begin
      sr_r <= {sr_r[5:0], cmd.bit_val};
    end
    if (gen) begin
      stg_r <= new_byte;
    end
    if (move) begin
      ocw_r   <= stg_r;
      olast_r <= cmd.fin;
      oeod_r  <= cmd.fin && cmd.eod;
      ost_r   <= cmd.status;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_codeword    = ocw_r;
  assign out_last_of_run = olast_r;
  assign out_end_of_data = oeod_r;
  assign out_status_code = ost_r;

endmodule

// ===== src/qrds_seq.sv =====
// Item sequencer: group arithmetic, stream state and the bit-serial walk over
// header, group, terminator, alignment and pad codewords. Depends on qrds_pkg.
module qrds_seq #(
  parameter int unsigned MAX_DATA_CODEWORDS    = qrds_pkg::MAX_DCW_DEF,
  parameter int unsigned MAX_RESULTS_PER_FLUSH = qrds_pkg::MAX_RES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  qrds_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [7:0]         in_char_code,
  input  qrds_pkg::pk_stat_t pk_stat,
  output qrds_pkg::pk_cmd_t  pk_cmd
);

  localparam int unsigned KW = $clog2(MAX_RESULTS_PER_FLUSH + 1);
  localparam logic [11:0] CapMax = 12'(MAX_DATA_CODEWORDS);
  localparam logic [KW-1:0] KMax = KW'(MAX_RESULTS_PER_FLUSH);

  qrds_pkg::seq_state_t state_r, state_nxt;
  qrds_pkg::phase_t     phase_r;

  logic          func_r;
  logic [7:0]    chr_r;
  logic [9:0]    pend_r;
  logic [1:0]    psize_r;
  logic          hdr_sent_r;
  logic [11:0]   cwe_r;
  logic [14:0]   total_r;
  logic          pad_tgl_r;
  logic [1:0]    flags_r;
  logic [10:0]   gv_r;
  logic [3:0]    gw_r;
  logic [14:0]   t1_r;
  logic          hdr_go_r;
  logic [2:0]    term_r;
  logic [4:0]    bidx_r, bidx_nxt;
  logic [KW-1:0] k_r;
  logic          eod_r;

  logic        accept, restart, is_fin, work, seg_end, pad_run, bit_state;
  logic [11:0] cap;
  logic [14:0] capbits;
  logic [4:0]  cw;
  logic        hdr_need;
  logic [4:0]  hdr_add;
  logic        digit_ok;
  logic [7:0]  dsub;
  logic [6:0]  aval;
  logic [13:0] pend10w;
  logic [15:0] p45w;
  logic [9:0]  pend_nxt;
  logic [1:0]  psize_nxt;
  logic [10:0] gv_nxt;
  logic [3:0]  gw_nxt;
  logic        inv;
  logic [15:0] t1_sum;
  logic [14:0] t1_nxt;
  logic        ovf;
  logic [14:0] diff;
  logic [2:0]  term_nxt;
  logic [2:0]  align_w;
  logic [15:0] sel_vec;
  logic [4:0]  bm1w;

  // Common conditions
  assign in_ready  = (state_r == qrds_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign restart   = accept && (in_func == qrds_pkg::FUNC_CHAR) &&
                     (phase_r != qrds_pkg::PH_COLLECT);
  assign is_fin    = (func_r == qrds_pkg::FUNC_FINISH);
  assign work      = !is_fin || (phase_r == qrds_pkg::PH_COLLECT);
  assign seg_end   = (bidx_r == 5'd0);
  assign cap       = (cfg.dcw > CapMax) ? CapMax : cfg.dcw;
  assign capbits   = {cap, 3'b000};
  assign pad_run   = (cwe_r < cap) && (k_r < KMax);
  assign bit_state = (state_r == qrds_pkg::S_HIND) || (state_r == qrds_pkg::S_HCNT) ||
                     (state_r == qrds_pkg::S_GRP) || (state_r == qrds_pkg::S_TERM) ||
                     (state_r == qrds_pkg::S_ALIGN);
  assign align_w   = 3'd0 - pk_stat.cnt;

  // Header and group arithmetic for the captured item
  always_comb begin
    cw        = qrds_pkg::count_width(cfg.mode, cfg.version);
    hdr_need  = !hdr_sent_r && work;
    hdr_add   = hdr_need ? (5'd4 + cw) : 5'd0;
    digit_ok  = (chr_r >= 8'h30) && (chr_r <= 8'h39);
    dsub      = chr_r - 8'h30;
    aval      = qrds_pkg::alnum_value(chr_r);
    pend10w   = {1'b0, pend_r, 3'b000} + {3'b000, pend_r, 1'b0} + {10'd0, dsub[3:0]};
    p45w      = {1'b0, pend_r, 5'd0} + {3'b000, pend_r, 3'd0} + {4'd0, pend_r, 2'd0} +
                {6'd0, pend_r} + {10'd0, aval[5:0]};
    pend_nxt  = pend_r;
    psize_nxt = psize_r;
    gv_nxt    = 11'd0;
    gw_nxt    = 4'd0;
    inv       = 1'b0;
    if (!is_fin) begin
      unique case (cfg.mode)
        qrds_pkg::MODE_NUMERIC: begin
          if (!digit_ok) begin
            inv = 1'b1;
          end else if (psize_r == 2'd2) begin
            gv_nxt    = {1'b0, pend10w[9:0]};
            gw_nxt    = 4'd10;
            pend_nxt  = 10'd0;
            psize_nxt = 2'd0;
          end else begin
            pend_nxt  = pend10w[9:0];
            psize_nxt = psize_r + 2'd1;
          end
        end
        qrds_pkg::MODE_ALNUM: begin
          if (!aval[6]) begin
            inv = 1'b1;
          end else if (psize_r == 2'd0) begin
            pend_nxt  = {4'd0, aval[5:0]};
            psize_nxt = 2'd1;
          end else begin
            gv_nxt    = p45w[10:0];
            gw_nxt    = 4'd11;
            pend_nxt  = 10'd0;
            psize_nxt = 2'd0;
          end
        end
        default: begin
          gv_nxt = {3'b000, chr_r};
          gw_nxt = 4'd8;
        end
      endcase
    end else begin
      // Flush the partial group
      gv_nxt    = {1'b0, pend_r};
      pend_nxt  = 10'd0;
      psize_nxt = 2'd0;
      unique case (cfg.mode)
        qrds_pkg::MODE_NUMERIC: begin
          if (psize_r == 2'd2) begin
            gw_nxt = 4'd7;
          end else if (psize_r == 2'd1) begin
            gw_nxt = 4'd4;
          end
        end
        qrds_pkg::MODE_ALNUM: begin
          if (psize_r != 2'd0) begin
            gw_nxt = 4'd6;
          end
        end
        default: gw_nxt = 4'd0;
      endcase
    end
    t1_sum = {1'b0, total_r} + {11'd0, hdr_add} + {12'd0, gw_nxt};
    t1_nxt = t1_sum[15] ? qrds_pkg::TOTAL_SAT : t1_sum[14:0];
  end

  // Overflow flag and terminator length
  always_comb begin
    ovf      = (t1_r > capbits);
    diff     = capbits - t1_r;
    term_nxt = (ovf || (diff > 15'd4)) ? 3'd4 : diff[2:0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qrds_pkg::S_IDLE:  if (accept) state_nxt = qrds_pkg::S_PREP1;
      qrds_pkg::S_PREP1: state_nxt = qrds_pkg::S_PREP2;
      qrds_pkg::S_PREP2: begin
        if (is_fin && (phase_r == qrds_pkg::PH_DONE)) begin
          state_nxt = qrds_pkg::S_FIN;
        end else if (is_fin && (phase_r == qrds_pkg::PH_PAD)) begin
          state_nxt = qrds_pkg::S_PAD;
        end else if (hdr_go_r) begin
          state_nxt = qrds_pkg::S_HIND;
        end else begin
          state_nxt = qrds_pkg::S_GRP;
        end
      end
      qrds_pkg::S_HIND:  if (seg_end) state_nxt = qrds_pkg::S_HCNT;
      qrds_pkg::S_HCNT:  if (seg_end) state_nxt = qrds_pkg::S_GRP;
      qrds_pkg::S_GRP: begin
        if (seg_end) state_nxt = is_fin ? qrds_pkg::S_TERM : qrds_pkg::S_FIN;
      end
      qrds_pkg::S_TERM:  if (seg_end) state_nxt = qrds_pkg::S_ALIGN;
      qrds_pkg::S_ALIGN: if (seg_end) state_nxt = qrds_pkg::S_PAD;
      qrds_pkg::S_PAD:   if (!pad_run) state_nxt = qrds_pkg::S_FIN;
      qrds_pkg::S_FIN: begin
        if (!pk_stat.stg_vld || pk_stat.out_free) state_nxt = qrds_pkg::S_IDLE;
      end
      default: state_nxt = qrds_pkg::S_IDLE;
    endcase
  end

  // Outputs: pick the next stream bit or pad codeword
  always_comb begin
    unique case (state_r)
      qrds_pkg::S_HIND: sel_vec = {12'd0, qrds_pkg::mode_ind(cfg.mode)};
      qrds_pkg::S_HCNT: sel_vec = {3'd0, cfg.mlen};
      qrds_pkg::S_GRP:  sel_vec = {5'd0, gv_r};
      default:          sel_vec = 16'd0;
    endcase
    bm1w             = bidx_r - 5'd1;
    pk_cmd           = '0;
    pk_cmd.bit_push  = bit_state && !seg_end && pk_stat.rdy;
    pk_cmd.bit_val   = sel_vec[bm1w[3:0]];
    pk_cmd.byte_push = (state_r == qrds_pkg::S_PAD) && pad_run && pk_stat.rdy;
    pk_cmd.byte_val  = pad_tgl_r ? qrds_pkg::PAD_SECOND : qrds_pkg::PAD_FIRST;
    pk_cmd.clr       = restart;
    pk_cmd.fin       = (state_r == qrds_pkg::S_FIN);
    pk_cmd.eod       = eod_r;
    pk_cmd.status    = flags_r;
  end

  // Segment bit counter
  always_comb begin
    bidx_nxt = bidx_r;
    if (state_r == qrds_pkg::S_PREP2) begin
      bidx_nxt = hdr_go_r ? 5'd4 : {1'b0, gw_r};
    end else if (bit_state && seg_end) begin
      unique case (state_r)
        qrds_pkg::S_HIND: bidx_nxt = cw;
        qrds_pkg::S_HCNT: bidx_nxt = {1'b0, gw_r};
        qrds_pkg::S_GRP:  bidx_nxt = {2'd0, term_r};
        qrds_pkg::S_TERM: bidx_nxt = {2'd0, align_w};
        default:          bidx_nxt = 5'd0;
      endcase
    end else if (pk_cmd.bit_push) begin
      bidx_nxt = bidx_r - 5'd1;
    end
  end

  // Control and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= qrds_pkg::S_IDLE;
      phase_r    <= qrds_pkg::PH_COLLECT;
      pend_r     <= 10'd0;
      psize_r    <= 2'd0;
      hdr_sent_r <= 1'b0;
      cwe_r      <= 12'd0;
      total_r    <= 15'd0;
      pad_tgl_r  <= 1'b0;
      flags_r    <= 2'd0;
      bidx_r     <= 5'd0;
      k_r        <= '0;
      eod_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bidx_r  <= bidx_nxt;
      if (accept) begin
        k_r   <= '0;
        eod_r <= 1'b0;
      end
      // Drop the finished stream when a new message starts
      if (restart) begin
        phase_r    <= qrds_pkg::PH_COLLECT;
        pend_r     <= 10'd0;
        psize_r    <= 2'd0;
        hdr_sent_r <= 1'b0;
        cwe_r      <= 12'd0;
        total_r    <= 15'd0;
        pad_tgl_r  <= 1'b0;
        flags_r    <= 2'd0;
      end
      if ((state_r == qrds_pkg::S_PREP1) && work) begin
        pend_r     <= pend_nxt;
        psize_r    <= psize_nxt;
        flags_r[0] <= flags_r[0] | inv;
      end
      if (state_r == qrds_pkg::S_PREP2) begin
        if (work) flags_r[1] <= flags_r[1] | ovf;
        hdr_sent_r <= hdr_sent_r | hdr_go_r;
      end
      if (pk_cmd.bit_push && (total_r != qrds_pkg::TOTAL_SAT)) begin
        total_r <= total_r + 15'd1;
      end
      if (pk_stat.gen) begin
        k_r <= k_r + 1'b1;
        if (cwe_r != qrds_pkg::CWE_SAT) cwe_r <= cwe_r + 12'd1;
      end
      if (pk_cmd.byte_push) begin
        pad_tgl_r <= ~pad_tgl_r;
      end
      if ((state_r == qrds_pkg::S_ALIGN) && seg_end) begin
        phase_r <= qrds_pkg::PH_PAD;
      end
      // Close the stream once capacity is reached
      if ((state_r == qrds_pkg::S_PAD) && !pad_run && (cwe_r >= cap)) begin
        phase_r <= qrds_pkg::PH_DONE;
        eod_r   <= 1'b1;
      end
    end
  end

  // Item payload and precomputed segment values
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      chr_r  <= in_char_code;
    end
    if (state_r == qrds_pkg::S_PREP1) begin
      gv_r     <= gv_nxt;
      gw_r     <= gw_nxt;
      t1_r     <= t1_nxt;
      hdr_go_r <= hdr_need;
    end
    if (state_r == qrds_pkg::S_PREP2) begin
      term_r <= term_nxt;
    end
  end

endmodule

// ===== src/qr_data_segment_encoder.sv =====
// QR data segment encoder, top level: configuration registers, sequencer and
// packer. Depends on qrds_pkg, qrds_seq and qrds_pack.
//
// Usage: write coding_mode, symbol_version, data_codewords and message_length
// on the cfg_ port (index 0..3) while the block is idle, then send one item
// per character (in_func = 0) and one or more finish items (in_func = 1).
// Both channels use valid/ready; one transfer moves one item or one codeword.
// The stream is built one bit per cycle, while the packer is ready, through a
// shift register, and the codewords leave through a one-byte staging stage and
// an output register. A character item passes setup states S_PREP1 and S_PREP2,
// then sends its bits segment by segment (header indicator 4 bits, count 8..16
// bits, group 0..11 bits), and releases its last codeword in S_FIN. A finish
// item adds terminator and alignment bits the same way, then one pad codeword
// per cycle while the packer is ready, at most MAX_RESULTS_PER_FLUSH results.
// A complete byte waits in staging until the next byte completes or the item ends.
// Reset restores the register defaults and clears the stream state.
// When the receiver stalls, the output register and staging byte fill and the
// bit shifting stops until out_ready returns; no codeword is lost.
module qr_data_segment_encoder #(
  parameter int unsigned MAX_DATA_CODEWORDS    = qrds_pkg::MAX_DCW_DEF,
  parameter int unsigned MAX_RESULTS_PER_FLUSH = qrds_pkg::MAX_RES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_codeword,
  output logic        out_last_of_run,
  output logic        out_end_of_data,
  output logic [1:0]  out_status_code
);

  qrds_pkg::cfg_t     cfg_r;
  qrds_pkg::pk_cmd_t  pk_cmd;
  qrds_pkg::pk_stat_t pk_stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode    <= qrds_pkg::MODE_BYTE;
      cfg_r.version <= 6'd1;
      cfg_r.dcw     <= 12'd19;
      cfg_r.mlen    <= 13'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qrds_pkg::REG_MODE:    cfg_r.mode    <= cfg_data[1:0];
        qrds_pkg::REG_VERSION: cfg_r.version <= cfg_data[5:0];
        qrds_pkg::REG_DCW:     cfg_r.dcw     <= cfg_data[11:0];
        qrds_pkg::REG_MLEN:    cfg_r.mlen    <= cfg_data;
        default: ;
      endcase
    end
  end

  qrds_seq #(
    .MAX_DATA_CODEWORDS    (MAX_DATA_CODEWORDS),
    .MAX_RESULTS_PER_FLUSH (MAX_RESULTS_PER_FLUSH)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_char_code (in_char_code),
    .pk_stat      (pk_stat),
    .pk_cmd       (pk_cmd)
  );

  qrds_pack u_pack (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (pk_cmd),
    .stat            (pk_stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_codeword    (out_codeword),
    .out_last_of_run (out_last_of_run),
    .out_end_of_data (out_end_of_data),
    .out_status_code (out_status_code)
  );

  // The stream end always closes an item's run
  a_eod_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_data |-> out_last_of_run)
    else $error("end_of_data without last_of_run");

  // One item at a time: no new transfer right after an accepted one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous item in work");

  // A new item never starts with a codeword still staged
  a_stage_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pk_stat.stg_vld)
    else $error("staged codeword left over at item start");

  // Bits and pad codewords are never pushed in the same cycle
  a_push_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(pk_cmd.bit_push && pk_cmd.byte_push))
    else $error("bit and pad codeword pushed together");

endmodule

// ===== verif/tb_qr_data_segment_encoder.sv =====
// Self-checking testbench for qr_data_segment_encoder: a clocked driver and monitor with
// an in-bench predictor of the QR data bit stream, codeword packing and padding.
// Depends on qrds_pkg and the encoder RTL only.
module tb_qr_data_segment_encoder;
  import qrds_pkg::*;

  typedef struct packed {
    logic       func;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic [7:0] codeword;
    logic       last;
    logic       eod;
    logic [1:0] status;
  } cw_t;

  localparam logic [1:0] ERR_INVALID  = 2'b01;
  localparam logic [1:0] ERR_OVERFLOW = 2'b10;
  localparam logic [3:0] IND_NUMERIC  = 4'b0001;
  localparam logic [3:0] IND_ALNUM    = 4'b0010;
  localparam logic [3:0] IND_BYTE     = 4'b0100;
  localparam logic [1:0] MODE_SPARE   = 2'd3;
  localparam logic [7:0] DIGIT_ZERO   = 8'h30;
  localparam logic [7:0] DIGIT_NINE   = 8'h39;
  localparam int unsigned ALNUM_RADIX   = 45;
  localparam int unsigned DIRECTED_ITEMS = 25;
  localparam int unsigned RANDOM_ITEMS   = 230;
  // A character item's work spans setup, a 16-bit count and an 11-bit group
  localparam int unsigned QUIET_CYCLES   = 64;
  localparam int unsigned CYCLE_LIMIT    = 1000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic [7:0]  in_char_code;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_codeword;
  logic        out_last_of_run;
  logic        out_end_of_data;
  logic [1:0]  out_status_code;

  qr_data_segment_encoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_codeword    (out_codeword),
    .out_last_of_run (out_last_of_run),
    .out_end_of_data (out_end_of_data),
    .out_status_code (out_status_code)
  );

  string       alnum_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";
  int unsigned version_edges [6] = '{1, 9, 10, 26, 27, 40};

  item_t item_pending [$];
  cw_t   cw_expected [$];
  cw_t   run_buf [$];

  // Predictor copy of the registers and the stream state
  cfg_t        cfg_now;
  logic [31:0] acc;
  int unsigned acc_bits;
  logic [9:0]  grp_val;
  logic [1:0]  grp_size;
  logic        hdr_done;
  logic [11:0] cw_sent;
  logic [14:0] bits_total;
  logic        pad_odd;
  phase_t      stream_phase;
  logic [1:0]  err_flags;
  logic        closed_now;

  int unsigned items_queued;
  int unsigned finishes_queued;
  int unsigned items_accepted;
  int unsigned codewords_checked;
  int unsigned messages;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned in_gap;
  int unsigned out_gap;
  bit          item_taken;
  bit          steady;

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] low_bits(input int unsigned n);
    return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
  endfunction

  function automatic int unsigned capacity();
    return (cfg_now.dcw > MAX_DCW_DEF) ? MAX_DCW_DEF : cfg_now.dcw;
  endfunction

  function automatic void restart_stream();
    acc          = '0;
    acc_bits     = 0;
    grp_val      = '0;
    grp_size     = '0;
    hdr_done     = 1'b0;
    cw_sent      = '0;
    bits_total   = '0;
    pad_odd      = 1'b0;
    stream_phase = PH_COLLECT;
    err_flags    = '0;
  endfunction

  function automatic void push_bits(input logic [31:0] val, input int unsigned n);
    int unsigned t;
    acc = (acc << n) | (val & low_bits(n));
    acc_bits += n;
    t = bits_total + n;
    bits_total = (t > TOTAL_SAT) ? TOTAL_SAT : t[14:0];
  endfunction

  function automatic void note_overflow();
    if (bits_total > capacity() * 8) err_flags |= ERR_OVERFLOW;
  endfunction

  function automatic void emit(input logic [7:0] b);
    cw_t r;
    r = '{codeword: b, last: 1'b0, eod: 1'b0, status: 2'b00};
    run_buf.push_back(r);
    if (cw_sent != CWE_SAT) cw_sent++;
  endfunction

  // Release every complete byte, oldest bits first
  function automatic void drain();
    logic [31:0] sh;
    while (acc_bits >= 8) begin
      sh = acc >> (acc_bits - 8);
      acc_bits -= 8;
      acc &= low_bits(acc_bits);
      emit(sh[7:0]);
    end
  endfunction

  function automatic void send_header();
    logic [3:0]  ind;
    int unsigned w;
    case (cfg_now.mode)
      MODE_NUMERIC: begin
        ind = IND_NUMERIC;
        w = (cfg_now.version < 10) ? 10 : (cfg_now.version < 27) ? 12 : 14;
      end
      MODE_ALNUM: begin
        ind = IND_ALNUM;
        w = (cfg_now.version < 10) ? 9 : (cfg_now.version < 27) ? 11 : 13;
      end
      default: begin
        ind = IND_BYTE;
        w = (cfg_now.version < 10) ? 8 : 16;
      end
    endcase
    push_bits(ind, 4);
    push_bits(cfg_now.mlen, w);
    hdr_done = 1'b1;
  endfunction

  function automatic int alnum_index(input logic [7:0] c);
    for (int i = 0; i < ALNUM_RADIX; i++) begin
      if (alnum_chars[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic void take_char(input logic [7:0] c);
    int v;
    int unsigned t;
    if (stream_phase != PH_COLLECT) restart_stream();
    if (!hdr_done) begin
      send_header();
      drain();
    end
    if (cfg_now.mode == MODE_NUMERIC) begin
      if (c >= DIGIT_ZERO && c <= DIGIT_NINE) begin
        t = grp_val * 10 + (c - DIGIT_ZERO);
        grp_val = t[9:0];
        grp_size++;
        if (grp_size == 2'd3) begin
          push_bits(grp_val, 10);
          grp_val = '0;
          grp_size = '0;
        end
      end else begin
        err_flags |= ERR_INVALID;
      end
    end else if (cfg_now.mode == MODE_ALNUM) begin
      v = alnum_index(c);
      if (v < 0) begin
        err_flags |= ERR_INVALID;
      end else if (grp_size == 0) begin
        grp_val = v[9:0];
        grp_size = 2'd1;
      end else begin
        push_bits(grp_val * ALNUM_RADIX + v, 11);
        grp_val = '0;
        grp_size = '0;
      end
    end else begin
      push_bits(c, 8);
    end
    note_overflow();
    drain();
  endfunction

  function automatic void take_finish();
    int unsigned cap;
    int unsigned capbits;
    int unsigned term;
    cap = capacity();
    capbits = cap * 8;
    if (stream_phase == PH_DONE) return;
    if (stream_phase == PH_COLLECT) begin
      if (!hdr_done) begin
        send_header();
        drain();
      end
      // Flush the partial group; byte mode drops it
      if (cfg_now.mode == MODE_NUMERIC) begin
        if (grp_size == 2) push_bits(grp_val, 7);
        else if (grp_size == 1) push_bits(grp_val, 4);
      end else if (cfg_now.mode == MODE_ALNUM) begin
        if (grp_size != 0) push_bits(grp_val, 6);
      end
      grp_val = '0;
      grp_size = '0;
      note_overflow();
      if (bits_total <= capbits) begin
        term = capbits - bits_total;
        if (term > 4) term = 4;
      end else begin
        term = 4;
      end
      push_bits('0, term);
      push_bits('0, (8 - (acc_bits & 7)) & 7);
      note_overflow();
      drain();
      stream_phase = PH_PAD;
    end
    while (cw_sent < cap && run_buf.size() < MAX_RES_DEF) begin
      emit(pad_odd ? PAD_SECOND : PAD_FIRST);
      pad_odd = ~pad_odd;
    end
    if (cw_sent >= cap) begin
      stream_phase = PH_DONE;
      closed_now = 1'b1;
    end
  endfunction

  // Work out every codeword one accepted item causes and queue it
  function automatic void encode_item(input logic func, input logic [7:0] c);
    cw_t r;
    run_buf.delete();
    closed_now = 1'b0;
    if (func == FUNC_CHAR) take_char(c);
    else take_finish();
    for (int i = 0; i < run_buf.size(); i++) begin
      r = run_buf[i];
      r.last = (i == run_buf.size() - 1);
      r.eod = r.last && closed_now;
      r.status = err_flags;
      cw_expected.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- helpers

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    fail_count++;
    if (fail_count <= 40)
      $display("mismatch at codeword %0d: %s got 0x%0h, expected 0x%0h",
               codewords_checked, what, got, want);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[12:0];
    case (idx)
      REG_MODE:    cfg_now.mode    = val[1:0];
      REG_VERSION: cfg_now.version = val[5:0];
      REG_DCW:     cfg_now.dcw     = val[11:0];
      default:     cfg_now.mlen    = val[12:0];
    endcase
  endtask

  task automatic set_config(input int unsigned mode, input int unsigned ver,
                            input int unsigned dcw, input int unsigned mlen);
    write_reg(REG_MODE, mode);
    write_reg(REG_VERSION, ver);
    write_reg(REG_DCW, dcw);
    write_reg(REG_MLEN, mlen);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_item(input logic func, input logic [7:0] c);
    item_t it;
    it.func = func;
    it.char_code = c;
    item_pending.push_back(it);
    items_queued++;
    if (func == FUNC_FINISH) finishes_queued++;
  endtask

  // Hold until all items are taken and all codewords are back, then let
  // the block settle in case the last item produced nothing
  task automatic wait_idle();
    while (!(item_pending.size() == 0 && !in_valid && cw_expected.size() == 0))
      @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] legal_char(input logic [1:0] mode);
    case (mode)
      MODE_NUMERIC: return DIGIT_ZERO + $urandom_range(0, 9);
      MODE_ALNUM:   return alnum_chars[$urandom_range(0, ALNUM_RADIX - 1)];
      default:      return $urandom_range(0, 255);
    endcase
  endfunction

  // ---------------------------------------------------------------- clock

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- input side

  // Record each transfer and predict its codewords
  always @(posedge clk) begin : item_accept
    if (rst_n && in_valid && in_ready) begin
      encode_item(in_func, in_char_code);
      items_accepted++;
      item_taken = 1'b1;
    end
  end

  // Offer the next pending item after a random gap; hold until transferred
  always @(negedge clk) begin : item_driver
    item_t nxt;
    logic  hold;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      hold = in_valid && !item_taken;
      item_taken = 1'b0;
      if (!hold) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (item_pending.size() > 0) begin
          nxt = item_pending.pop_front();
          in_valid     <= 1'b1;
          in_func      <= nxt.func;
          in_char_code <= nxt.char_code;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- output side

  // Stall the receiver at random
  always @(negedge clk) begin : sink_stall
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) out_gap = pick_gap();
    end
  end

  // Compare each codeword transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    cw_t want;
    if (rst_n && out_valid && out_ready) begin
      if (cw_expected.size() == 0) begin
        report_mismatch("codeword with none expected", out_codeword, 0);
      end else begin
        want = cw_expected.pop_front();
        if (out_codeword !== want.codeword)
          report_mismatch("codeword", out_codeword, want.codeword);
        if (out_last_of_run !== want.last)
          report_mismatch("last_of_run", out_last_of_run, want.last);
        if (out_end_of_data !== want.eod)
          report_mismatch("end_of_data", out_end_of_data, want.eod);
        if (out_status_code !== want.status)
          report_mismatch("status_code", out_status_code, want.status);
      end
      codewords_checked++;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d codewords still expected",
               cycle_count, cw_expected.size());
      $display("tb_qr_data_segment_encoder: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    int unsigned r;
    int unsigned nchars;
    int unsigned nfin;
    int unsigned cap;
    int unsigned ver;
    int unsigned dcw;
    int unsigned mlen;
    logic [1:0]  mode;
    bit          open_msg;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_MODE;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_func      = FUNC_CHAR;
    in_char_code = '0;
    out_ready    = 1'b0;
    in_gap       = 0;
    out_gap      = 0;
    item_taken   = 1'b0;
    steady       = 1'b0;
    cfg_now      = '{mode: MODE_BYTE, version: 6'd1, dcw: 12'd19, mlen: 13'd0};
    restart_stream();
    closed_now   = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty message under reset settings, then a finish once already done
    add_item(FUNC_FINISH, 8'h00);
    add_item(FUNC_FINISH, 8'hA5);
    messages++;
    wait_idle();

    // Numeric: full groups, a bad digit, a lone trailing digit
    set_config(MODE_NUMERIC, 9, 5, 0);
    add_item(FUNC_CHAR, "0");
    add_item(FUNC_CHAR, "1");
    add_item(FUNC_CHAR, "2");
    add_item(FUNC_CHAR, "9");
    add_item(FUNC_CHAR, "x");
    add_item(FUNC_CHAR, "8");
    add_item(FUNC_CHAR, "7");
    add_item(FUNC_CHAR, "5");
    add_item(FUNC_FINISH, 8'h00);
    messages++;
    wait_idle();

    // Alphanumeric past a one-codeword capacity, lowercase rejected
    set_config(MODE_ALNUM, 10, 1, 7089);
    add_item(FUNC_CHAR, "A");
    add_item(FUNC_CHAR, "Z");
    add_item(FUNC_CHAR, "a");
    add_item(FUNC_CHAR, " ");
    add_item(FUNC_CHAR, ":");
    add_item(FUNC_CHAR, "$");
    add_item(FUNC_FINISH, 8'hFF);
    messages++;
    wait_idle();

    // Numeric stream that fills capacity exactly: finish yields nothing
    set_config(MODE_NUMERIC, 1, 3, 0);
    add_item(FUNC_CHAR, "1");
    add_item(FUNC_CHAR, "2");
    add_item(FUNC_CHAR, "3");
    add_item(FUNC_FINISH, 8'h00);
    messages++;
    wait_idle();

    // Spare mode code behaves as byte mode, wide count field
    set_config(MODE_SPARE, 27, 4, 7089);
    add_item(FUNC_CHAR, 8'h00);
    add_item(FUNC_CHAR, 8'hFF);
    add_item(FUNC_FINISH, 8'h00);
    messages++;

    // Random messages, some left open so the next settings land mid-message
    while (items_queued < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      wait_idle();
      steady = ($urandom_range(0, 4) == 0);

      r = $urandom_range(0, 19);
      mode = (r < 6) ? MODE_NUMERIC : (r < 12) ? MODE_ALNUM : (r < 19) ? MODE_BYTE
                                                                       : MODE_SPARE;
      ver = ($urandom_range(0, 1) == 0) ? version_edges[$urandom_range(0, 5)]
                                         : $urandom_range(1, 40);
      r = $urandom_range(0, 99);
      if (messages == 8) dcw = 1;
      else if (messages == 12) dcw = 4095;
      else if (r < 60) dcw = $urandom_range(1, 24);
      else if (r < 92) dcw = $urandom_range(25, 80);
      else dcw = $urandom_range(81, 300);
      if (messages == 10) mlen = 7089;
      else if ($urandom_range(0, 1) == 0) mlen = $urandom_range(0, 7089);
      else mlen = $urandom_range(0, 20);
      set_config(mode, ver, dcw, mlen);

      nchars = (messages == 12) ? 2 :
               ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 14);
      for (int i = 0; i < nchars; i++) begin
        if ($urandom_range(0, 99) < 85) add_item(FUNC_CHAR, legal_char(mode));
        else add_item(FUNC_CHAR, $urandom_range(0, 255));
      end

      open_msg = (messages != 12) && ($urandom_range(0, 3) == 0);
      if (!open_msg) begin
        cap = (dcw > MAX_DCW_DEF) ? MAX_DCW_DEF : dcw;
        // Sometimes stop a long pad run early so the next message restarts it
        if (cap > MAX_RES_DEF && messages != 12 && $urandom_range(0, 6) == 0) nfin = 1;
        else nfin = cap / MAX_RES_DEF + 1 + $urandom_range(0, 1);
        for (int i = 0; i < nfin; i++) add_item(FUNC_FINISH, $urandom_range(0, 255));
      end
      messages++;
    end

    steady = 1'b0;
    wait_idle();

    $display("covered %0d items (%0d finish) over %0d messages, %0d codewords checked",
             items_accepted, finishes_queued, messages, codewords_checked);
    $display("settings spanned all modes, versions 1..40, capacities 1..4095; %0d mismatches",
             fail_count);
    if (fail_count == 0) begin
      $display("tb_qr_data_segment_encoder: PASS");
    end else begin
      $display("tb_qr_data_segment_encoder: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/qrds_pkg.sv
src/qrds_pack.sv
src/qrds_seq.sv
src/qr_data_segment_encoder.sv
verif/tb_qr_data_segment_encoder.sv
